/* design/ert_pkg.sv */
// Shared types and constants for the event trace ring.
`default_nettype none

package ert_pkg;

    localparam int SEQ_W      = 32;
    localparam int CODE_W     = 16;
    localparam int SEV_W      = 3;
    localparam int SLOT_W     = 8;
    localparam int CORR_W     = 16;
    localparam int STAMP_W    = 32;
    localparam int BOOT_W     = 32;
    localparam int AGE_W      = 8;
    localparam int FILL_W     = 6;
    localparam int JRNL_W     = 16;
    localparam int ACTION_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_EMIT  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_FLUSH = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_ID    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEV_FLOOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JRNL_LIMIT = 2'd2;

    localparam logic [BOOT_W-1:0] BOOT_ID_RST    = '0;
    localparam logic [SEV_W-1:0]  SEV_FLOOR_RST  = 3'd1;
    localparam logic [JRNL_W-1:0] JRNL_LIMIT_RST = 16'd1024;

    typedef struct packed {
        logic [SEQ_W-1:0]   seq;
        logic [CODE_W-1:0]  code;
        logic [SEV_W-1:0]   severity;
        logic [SLOT_W-1:0]  slot;
        logic [CORR_W-1:0]  corr_id;
        logic [STAMP_W-1:0] stamp;
        logic [BOOT_W-1:0]  boot_id;
    } entry_t;

    typedef enum logic [1:0] {
        OSEL_ZERO,
        OSEL_EMIT,
        OSEL_RDATA,
        OSEL_HOLD
    } out_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMIT,
        S_READ_REQ,
        S_READ_OUT,
        S_CLEAR,
        S_FL_START,
        S_FL_REQ,
        S_FL_EVAL,
        S_FL_END
    } state_t;

    typedef struct packed {
        logic     in_ready;
        logic     emit;
        logic     clear;
        logic     walk_start;
        logic     walk_adv;
        logic     take;
        logic     commit;
        logic     rd_walk;
        logic     out_load;
        out_sel_t out_sel;
        logic     out_res_valid;
        logic     out_save;
        logic     out_last;
    } ert_cmd_t;

    typedef struct packed {
        logic    in_valid;
        action_t action;
        logic    out_free;
        logic    fill_zero;
        logic    read_hit;
        logic    qual;
        logic    at_limit;
        logic    hold_valid;
        logic    walk_last;
    } ert_sts_t;

endpackage

`default_nettype wire

/* design/ert_ifs.sv */
// Channel interfaces: event input, result output, configuration write.
`default_nettype none

interface ert_evt_if import ert_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [CODE_W-1:0]   code;
    logic [SEV_W-1:0]    severity;
    logic [SLOT_W-1:0]   slot;
    logic [CORR_W-1:0]   corr_id;
    logic [STAMP_W-1:0]  stamp;
    logic [AGE_W-1:0]    age_index;

    modport source (
        output valid, action, code, severity, slot, corr_id, stamp, age_index,
        input  ready
    );
    modport sink (
        input  valid, action, code, severity, slot, corr_id, stamp, age_index,
        output ready
    );
endinterface

interface ert_res_if import ert_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               valid_res;
    logic [SEQ_W-1:0]   seq;
    logic [CODE_W-1:0]  out_code;
    logic [SEV_W-1:0]   out_severity;
    logic [SLOT_W-1:0]  out_slot;
    logic [CORR_W-1:0]  out_corr_id;
    logic [STAMP_W-1:0] out_stamp;
    logic [BOOT_W-1:0]  out_boot_id;
    logic [FILL_W-1:0]  fill;
    logic               save_request;
    logic               last;

    modport source (
        output valid, valid_res, seq, out_code, out_severity, out_slot, out_corr_id,
               out_stamp, out_boot_id, fill, save_request, last,
        input  ready
    );
    modport sink (
        input  valid, valid_res, seq, out_code, out_severity, out_slot, out_corr_id,
               out_stamp, out_boot_id, fill, save_request, last,
        output ready
    );
endinterface

interface ert_cfg_if import ert_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

/* design/ert_ctrl.sv */
// Sequencing state machine for emit, read, flush walk and clear.
`default_nettype none

module ert_ctrl import ert_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire ert_sts_t sts,
    output ert_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd         = '0;
        cmd.out_sel = OSEL_ZERO;
        state_next  = state_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    unique case (sts.action)
                        ACT_EMIT:  state_next = S_EMIT;
                        ACT_READ:  state_next = S_READ_REQ;
                        ACT_FLUSH: state_next = S_FL_START;
                        ACT_CLEAR: state_next = S_CLEAR;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end

            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit          = 1'b1;
                    cmd.out_load      = 1'b1;
                    cmd.out_sel       = OSEL_EMIT;
                    cmd.out_res_valid = 1'b1;
                    cmd.out_last      = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            // read data lands in the registered memory output by the next cycle
            S_READ_REQ:
            begin
                state_next = S_READ_OUT;
            end

            S_READ_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load      = 1'b1;
                    cmd.out_sel       = sts.read_hit ? OSEL_RDATA : OSEL_ZERO;
                    cmd.out_res_valid = sts.read_hit;
                    cmd.out_last      = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            S_CLEAR:
            begin
                if (sts.out_free)
                begin
                    cmd.clear         = 1'b1;
                    cmd.out_load      = 1'b1;
                    cmd.out_sel       = OSEL_ZERO;
                    cmd.out_res_valid = 1'b1;
                    cmd.out_last      = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            S_FL_START:
            begin
                if (sts.fill_zero)
                begin
                    if (sts.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_last = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_FL_REQ;
                end
            end

            S_FL_REQ:
            begin
                cmd.rd_walk = 1'b1;
                state_next  = S_FL_EVAL;
            end

            // one taken entry is held back so the final one can carry last
            S_FL_EVAL:
            begin
                cmd.rd_walk = 1'b1;
                if (sts.qual && sts.at_limit)
                begin
                    state_next = S_FL_END;
                end
                else if (sts.qual)
                begin
                    if (!sts.hold_valid || sts.out_free)
                    begin
                        if (sts.hold_valid)
                        begin
                            cmd.out_load      = 1'b1;
                            cmd.out_sel       = OSEL_HOLD;
                            cmd.out_res_valid = 1'b1;
                        end
                        cmd.take     = 1'b1;
                        cmd.walk_adv = 1'b1;
                        state_next   = sts.walk_last ? S_FL_END : S_FL_REQ;
                    end
                end
                else
                begin
                    cmd.walk_adv = 1'b1;
                    state_next   = sts.walk_last ? S_FL_END : S_FL_REQ;
                end
            end

            S_FL_END:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    if (sts.hold_valid)
                    begin
                        cmd.out_sel       = OSEL_HOLD;
                        cmd.out_res_valid = 1'b1;
                        cmd.out_save      = 1'b1;
                        cmd.commit        = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/ert_datapath.sv */
// Ring storage, pointers, counters, config registers and result register.
`default_nettype none

module ert_datapath import ert_pkg::*; #(
    parameter int RING_DEPTH = 32,
    parameter int SAVE_EVERY = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ert_evt_if.sink   evt,
    ert_res_if.source res,
    ert_cfg_if.sink   cfg,
    input  wire ert_cmd_t cmd,
    output ert_sts_t  sts
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam int SW = $clog2(SAVE_EVERY + 1);
    localparam logic [AW:0]   DEPTH_W = (AW+1)'(RING_DEPTH);
    localparam logic [FW-1:0] DEPTH_F = FW'(RING_DEPTH);
    localparam logic [SW:0]   SAVE_W  = (SW+1)'(SAVE_EVERY);

    // position arithmetic: sums stay below twice the depth
    function automatic logic [AW-1:0] wrap_pos(input logic [AW:0] sum);
        logic [AW:0] red;
        red = (sum >= DEPTH_W) ? sum - DEPTH_W : sum;
        return red[AW-1:0];
    endfunction

    entry_t ring_mem [RING_DEPTH];
    entry_t rd_data_reg;

    logic [AW-1:0]     oldest_reg,  oldest_next;
    logic [FW-1:0]     fill_reg,    fill_next;
    logic [SEQ_W-1:0]  seq_reg,     seq_next;
    logic [SW-1:0]     cnt_reg,     cnt_next;
    logic [JRNL_W-1:0] journal_reg, journal_next;
    logic [BOOT_W-1:0] boot_reg,    boot_next;
    logic [SEV_W-1:0]  floor_reg,   floor_next;
    logic [JRNL_W-1:0] limit_reg,   limit_next;
    logic [FW-1:0]     walk_reg,    walk_next;
    logic [FW-1:0]     taken_reg,   taken_next;
    logic              hold_valid_reg, hold_valid_next;
    logic              out_valid_reg,  out_valid_next;

    logic [CODE_W-1:0]  code_reg;
    logic [SEV_W-1:0]   sev_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [CORR_W-1:0]  corr_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic [AGE_W-1:0]   age_reg;
    entry_t             hold_reg;

    entry_t             out_entry_reg;
    logic               out_res_valid_reg;
    logic [FILL_W-1:0]  out_fill_reg;
    logic               out_save_reg;
    logic               out_last_reg;

    logic          accept;
    logic [AW:0]   oldest_ext;
    logic [AW:0]   fill_ext;
    logic [AW:0]   age_off;
    logic [AW-1:0] wr_pos;
    logic [AW-1:0] age_pos;
    logic [AW-1:0] walk_pos;
    logic [AW-1:0] rd_addr;
    logic          full;
    logic [SW:0]   cnt_inc;
    logic          emit_save;
    logic [JRNL_W:0] jsum;
    entry_t        emit_entry;
    entry_t        out_entry_sel;

    assign accept    = evt.valid && cmd.in_ready;
    assign evt.ready = cmd.in_ready;
    assign cfg.ready = 1'b1;

    assign oldest_ext = {1'b0, oldest_reg};
    assign fill_ext   = (AW+1)'(fill_reg);
    assign age_off    = fill_ext - (AW+1)'(age_reg) - (AW+1)'(1);
    assign wr_pos     = wrap_pos(oldest_ext + fill_ext);
    assign age_pos    = wrap_pos(oldest_ext + age_off);
    assign walk_pos   = wrap_pos(oldest_ext + (AW+1)'(walk_reg));
    assign rd_addr    = cmd.rd_walk ? walk_pos : age_pos;
    assign full       = (fill_reg == DEPTH_F);

    assign cnt_inc   = {1'b0, cnt_reg} + (SW+1)'(1);
    assign emit_save = (cnt_inc >= SAVE_W);
    assign jsum      = (JRNL_W+1)'(journal_reg) + (JRNL_W+1)'(taken_reg);

    assign emit_entry = '{
        seq:      seq_reg,
        code:     code_reg,
        severity: sev_reg,
        slot:     slot_reg,
        corr_id:  corr_reg,
        stamp:    stamp_reg,
        boot_id:  boot_reg
    };

    assign sts.in_valid   = evt.valid;
    assign sts.action     = action_t'(evt.action);
    assign sts.out_free   = !out_valid_reg || res.ready;
    assign sts.fill_zero  = (fill_reg == '0);
    assign sts.read_hit   = ((AGE_W+1)'(age_reg) < (AGE_W+1)'(fill_reg));
    assign sts.qual       = (rd_data_reg.severity >= floor_reg);
    assign sts.at_limit   = (jsum >= {1'b0, limit_reg});
    assign sts.hold_valid = hold_valid_reg;
    assign sts.walk_last  = ((FW+1)'(walk_reg) + (FW+1)'(1) == (FW+1)'(fill_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            ring_mem[wr_pos] <= emit_entry;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    always_comb
    begin
        oldest_next     = oldest_reg;
        fill_next       = fill_reg;
        seq_next        = seq_reg;
        cnt_next        = cnt_reg;
        journal_next    = journal_reg;
        boot_next       = boot_reg;
        floor_next      = floor_reg;
        limit_next      = limit_reg;
        walk_next       = walk_reg;
        taken_next      = taken_reg;
        hold_valid_next = hold_valid_reg;

        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_BOOT_ID:    boot_next  = cfg.data;
                CFG_SEV_FLOOR:  floor_next = cfg.data[SEV_W-1:0];
                CFG_JRNL_LIMIT: limit_next = cfg.data[JRNL_W-1:0];
                default:        ;
            endcase
        end

        if (cmd.emit)
        begin
            seq_next = seq_reg + SEQ_W'(1);
            if (full)
            begin
                oldest_next = wrap_pos(oldest_ext + (AW+1)'(1));
            end
            else
            begin
                fill_next = fill_reg + FW'(1);
            end
            cnt_next = emit_save ? '0 : cnt_inc[SW-1:0];
        end

        if (cmd.clear)
        begin
            oldest_next  = '0;
            fill_next    = '0;
            journal_next = '0;
        end

        if (cmd.walk_start)
        begin
            walk_next       = '0;
            taken_next      = '0;
            hold_valid_next = 1'b0;
            if (journal_reg >= limit_reg)
            begin
                journal_next = '0;
            end
        end

        if (cmd.walk_adv)
        begin
            walk_next = walk_reg + FW'(1);
        end

        if (cmd.take)
        begin
            taken_next      = taken_reg + FW'(1);
            hold_valid_next = 1'b1;
        end

        if (cmd.commit)
        begin
            journal_next = jsum[JRNL_W-1:0];
            cnt_next     = '0;
        end

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_comb
    begin
        case (cmd.out_sel)
            OSEL_EMIT:  out_entry_sel = emit_entry;
            OSEL_RDATA: out_entry_sel = rd_data_reg;
            OSEL_HOLD:  out_entry_sel = hold_reg;
            default:    out_entry_sel = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg     <= '0;
            fill_reg       <= '0;
            seq_reg        <= '0;
            cnt_reg        <= '0;
            journal_reg    <= '0;
            boot_reg       <= BOOT_ID_RST;
            floor_reg      <= SEV_FLOOR_RST;
            limit_reg      <= JRNL_LIMIT_RST;
            walk_reg       <= '0;
            taken_reg      <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            oldest_reg     <= oldest_next;
            fill_reg       <= fill_next;
            seq_reg        <= seq_next;
            cnt_reg        <= cnt_next;
            journal_reg    <= journal_next;
            boot_reg       <= boot_next;
            floor_reg      <= floor_next;
            limit_reg      <= limit_next;
            walk_reg       <= walk_next;
            taken_reg      <= taken_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg  <= evt.code;
            sev_reg   <= evt.severity;
            slot_reg  <= evt.slot;
            corr_reg  <= evt.corr_id;
            stamp_reg <= evt.stamp;
            age_reg   <= evt.age_index;
        end
        if (cmd.take)
        begin
            hold_reg <= rd_data_reg;
        end
        if (cmd.out_load)
        begin
            out_entry_reg     <= out_entry_sel;
            out_res_valid_reg <= cmd.out_res_valid;
            out_fill_reg      <= FILL_W'(fill_next);
            out_save_reg      <= (cmd.out_sel == OSEL_EMIT) ? emit_save : cmd.out_save;
            out_last_reg      <= cmd.out_last;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.valid_res    = out_res_valid_reg;
    assign res.seq          = out_entry_reg.seq;
    assign res.out_code     = out_entry_reg.code;
    assign res.out_severity = out_entry_reg.severity;
    assign res.out_slot     = out_entry_reg.slot;
    assign res.out_corr_id  = out_entry_reg.corr_id;
    assign res.out_stamp    = out_entry_reg.stamp;
    assign res.out_boot_id  = out_entry_reg.boot_id;
    assign res.fill         = out_fill_reg;
    assign res.save_request = out_save_reg;
    assign res.last         = out_last_reg;

endmodule

`default_nettype wire

/* design/event_trace_ring.sv */
// Event trace ring: stores stamped events in a circular buffer, reads by age, flushes to journal.
// Channels: evt takes one action per transaction (emit, read by age, flush, clear); res returns
// results, one per emit, read or clear, and one per taken entry for a flush, or one with
// valid_res low if none is taken (last marks the final one); cfg writes boot_id (0),
// severity_floor (1) and journal_limit (2) at any time the block is idle, one write per cycle.
// Order: an emit or clear result is loaded into the output register from S_EMIT or S_CLEAR,
// a read's from S_READ_OUT after S_READ_REQ. A flush reads the ring oldest first through the
// single memory read port, S_FL_REQ then S_FL_EVAL per entry walked; its results come out as
// the walk goes. Throughput: one item at a time; evt.ready is high only between actions.
// The next item is accepted while a finished result is still held.
// Reset: rst_n clears the ring pointers, fill, sequence counter, save counter and journal count
// and loads the register defaults; ring contents need no clearing since only entries within
// fill are ever read. No clearing pass is run.
// Receiver stall: the result sits in the output register while res.ready is low, and the
// sequencer waits in place before loading the next result; nothing is dropped.
`default_nettype none

module event_trace_ring import ert_pkg::*; #(
    parameter int RING_DEPTH = 32,
    parameter int SAVE_EVERY = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ert_evt_if.sink   evt,
    ert_res_if.source res,
    ert_cfg_if.sink   cfg
);

    ert_cmd_t cmd;
    ert_sts_t sts;

    ert_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    ert_datapath #(
        .RING_DEPTH (RING_DEPTH),
        .SAVE_EVERY (SAVE_EVERY)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .res   (res),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule

`default_nettype wire
